>>> hdl/ccpu_pkg.sv
// ccpu_pkg: shared types and constants for the camera command and pattern unit
// transaction payloads, function codes, reply kinds, mode tables, control structs
// no dependencies
`default_nettype none

package ccpu_pkg;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] mode_select;
    logic [31:0] trigger_state;
    logic [31:0] product_given;
    logic [31:0] serial_given;
    logic [7:0]  sensor_address;
    logic [15:0] sensor_value;
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic        status_error;
    logic [7:0]  read_address;
    logic [15:0] read_value;
    logic        was_undefined;
    logic        was_unsupported;
    logic [7:0]  pixel_value;
    logic [9:0]  frame_width;
    logic [8:0]  frame_height;
    logic [15:0] frame_count;
  } rsp_item_t;

  // function codes
  localparam logic [3:0] FN_DISCOVER  = 4'd0;
  localparam logic [3:0] FN_CONFIGURE = 4'd1;
  localparam logic [3:0] FN_TRIGGER   = 4'd2;
  localparam logic [3:0] FN_MODE      = 4'd3;
  localparam logic [3:0] FN_START     = 4'd4;
  localparam logic [3:0] FN_STOP      = 4'd5;
  localparam logic [3:0] FN_RESET     = 4'd6;
  localparam logic [3:0] FN_READ      = 4'd7;
  localparam logic [3:0] FN_WRITE     = 4'd8;
  localparam logic [3:0] FN_PIXEL     = 4'd9;
  localparam logic [3:0] FN_FRAME_END = 4'd10;

  // reply kinds
  localparam logic [1:0] RK_STATUS   = 2'd0;
  localparam logic [1:0] RK_ANNOUNCE = 2'd1;
  localparam logic [1:0] RK_SENSOR   = 2'd2;
  localparam logic [1:0] RK_PIXEL    = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SERIAL  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRODUCT = 2'd1;

  localparam logic [31:0] SERIAL_RESET  = 32'd12345;
  localparam logic [31:0] PRODUCT_RESET = 32'd0;

  localparam logic [7:0]  CTRL_REG      = 8'h7F;
  localparam logic [15:0] PATTERN_MASK  = 16'h3C00;
  localparam logic [15:0] PATTERN_CODE  = 16'h3800;
  localparam logic [31:0] MODE_COUNT    = 32'd10;
  localparam logic [9:0]  WIDTH_RESET   = 10'd640;
  localparam logic [8:0]  HEIGHT_RESET  = 9'd480;
  localparam logic [9:0]  NARROW_WIDTH  = 10'd320;
  localparam logic [10:0] DIAG_LIMIT    = 11'd500;
  localparam logic [7:0]  DIAG_OFFSET   = 8'd14;

  function automatic logic [9:0] mode_width(input logic [3:0] idx);
    logic [9:0] w;
    case (idx)
      4'd0, 4'd1:                   w = 10'd752;
      4'd2, 4'd3, 4'd4, 4'd5:       w = 10'd640;
      default:                      w = 10'd320;
    endcase
    return w;
  endfunction

  function automatic logic [8:0] mode_height(input logic [3:0] idx);
    logic [8:0] h;
    case (idx)
      4'd6, 4'd7, 4'd8, 4'd9:       h = 9'd240;
      default:                      h = 9'd480;
    endcase
    return h;
  endfunction

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_result;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hdl/camera_command_and_pattern_unit.sv
// camera_command_and_pattern_unit: command checker and test pattern generator
// an item is registered at capture and its result at execute; execute holds while an earlier result waits
// sequence: capture plus bank read, then execute; the next item is taken only after execute
// a new item is taken while the previous result still waits in the output register
// reset: synchronous; clears control state, the streaming flag, the test pattern flag, mode size,
// frame counter, result valid and sensor register write marks; no clearing pass
`default_nettype none

module camera_command_and_pattern_unit #(
  parameter int unsigned SENSOR_REG_COUNT = 256
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cmd_valid,
  output logic                             cmd_ready,
  input  ccpu_pkg::cmd_item_t              cmd_item,
  output logic                             rsp_valid,
  input  wire                              rsp_ready,
  output ccpu_pkg::rsp_item_t              rsp_item,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [ccpu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire [31:0]                       cfg_data
);
  import ccpu_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  assign cfg_ready = !rst;

  ccpu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  ccpu_dpath #(
    .SENSOR_REG_COUNT (SENSOR_REG_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .cmd_item  (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

>>> hdl/ccpu_ctrl.sv
// ccpu_ctrl: controller state machine, sequences capture and commit of one item
// depends on ccpu_pkg
`default_nettype none

module ccpu_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cmd_valid,
  output logic                  cmd_ready,
  input  ccpu_pkg::dp_status_t  status,
  output ccpu_pkg::ctrl_cmd_t   ctrl
);
  import ccpu_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) state_next = ST_WORK;
      end
      ST_WORK: begin
        // hold while a result has nowhere to go
        if (!(status.has_result && status.out_busy)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready    = 1'b0;
    ctrl.capture = 1'b0;
    ctrl.commit  = 1'b0;
    case (state)
      ST_IDLE: begin
        // nothing is taken while in reset
        cmd_ready    = !rst;
        ctrl.capture = cmd_valid && !rst;
      end
      ST_WORK: begin
        ctrl.commit = !(status.has_result && status.out_busy);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/ccpu_dpath.sv
// ccpu_dpath: item register, camera state, sensor register bank, pixel generator,
// configuration registers and result register
// depends on ccpu_pkg
`default_nettype none

module ccpu_dpath #(
  parameter int unsigned SENSOR_REG_COUNT = 256
) (
  input  wire                                clk,
  input  wire                                rst,
  input  ccpu_pkg::ctrl_cmd_t                ctrl,
  output ccpu_pkg::dp_status_t               status,
  input  ccpu_pkg::cmd_item_t                cmd_item,
  output logic                               rsp_valid,
  input  wire                                rsp_ready,
  output ccpu_pkg::rsp_item_t                rsp_item,
  input  wire                                cfg_valid,
  input  wire [ccpu_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire [31:0]                         cfg_data
);
  import ccpu_pkg::*;

  localparam int unsigned IDX_W = $clog2(SENSOR_REG_COUNT);
  localparam logic [8:0] REG_COUNT_V = 9'(SENSOR_REG_COUNT);

  // configuration
  logic [31:0] serial_number, product_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      serial_number <= SERIAL_RESET;
      product_code  <= PRODUCT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SERIAL)  serial_number <= cfg_data;
      if (cfg_index == CFG_PRODUCT) product_code  <= cfg_data;
    end
  end

  // captured item and registered bank read
  cmd_item_t item;
  logic [15:0] sensor_mem [SENSOR_REG_COUNT];
  logic [15:0] rd_data;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      item    <= cmd_item;
      rd_data <= sensor_mem[cmd_item.sensor_address[IDX_W-1:0]];
    end
  end

  // camera state
  logic        streaming, streaming_next;
  logic [9:0]  line_width, line_width_next;
  logic [8:0]  line_count, line_count_next;
  logic [15:0] frame_counter, frame_counter_next;
  logic        test_pattern, test_pattern_next;
  logic [SENSOR_REG_COUNT-1:0] written;
  logic        clear_written;

  logic [IDX_W-1:0] idx;
  logic             in_bank, is_ctrl, mem_we;

  assign idx     = item.sensor_address[IDX_W-1:0];
  assign in_bank = {1'b0, item.sensor_address} < REG_COUNT_V;
  assign is_ctrl = item.sensor_address == CTRL_REG;

  // pixel generator
  logic [10:0] full_sum, half_sum;
  logic [7:0]  full_val, half_val, plain_val, pix;

  always_comb begin
    full_sum  = 11'({1'b0, item.pixel_x} + 11'd1) >> 1;
    full_sum  = full_sum + 11'(item.pixel_y);
    half_sum  = 11'(item.pixel_x) + {1'b0, item.pixel_y, 1'b0};
    full_val  = DIAG_OFFSET + item.pixel_x[9:2];
    half_val  = DIAG_OFFSET + item.pixel_x[8:1];
    plain_val = item.pixel_x[7:0] + item.pixel_y[7:0] + frame_counter[7:0];
    if (!test_pattern) begin
      pix = plain_val;
    end else if (line_width > NARROW_WIDTH) begin
      pix = (full_sum < DIAG_LIMIT) ? full_val : 8'd0;
    end else if (half_sum + 11'd1 < DIAG_LIMIT) begin
      pix = half_val;
    end else if (half_sum < DIAG_LIMIT) begin
      pix = {1'b0, half_val[7:1]};
    end else begin
      pix = 8'd0;
    end
  end

  // command decode
  logic      has_res;
  rsp_item_t res;

  always_comb begin
    has_res            = 1'b0;
    res                = '0;
    streaming_next     = streaming;
    line_width_next    = line_width;
    line_count_next    = line_count;
    frame_counter_next = frame_counter;
    test_pattern_next  = test_pattern;
    clear_written      = 1'b0;
    mem_we             = 1'b0;
    case (item.func)
      FN_DISCOVER: begin
        has_res        = 1'b1;
        res.reply_kind = RK_ANNOUNCE;
      end
      FN_CONFIGURE: begin
        if (item.product_given == product_code && item.serial_given == serial_number) begin
          has_res        = 1'b1;
          res.reply_kind = RK_ANNOUNCE;
          streaming_next = 1'b0;
        end
      end
      FN_TRIGGER: begin
        has_res          = 1'b1;
        res.status_error = !(item.trigger_state == 32'd0 && !streaming);
      end
      FN_MODE: begin
        has_res = 1'b1;
        if (item.mode_select >= MODE_COUNT || streaming) begin
          res.status_error = 1'b1;
        end else begin
          line_width_next = mode_width(item.mode_select[3:0]);
          line_count_next = mode_height(item.mode_select[3:0]);
        end
      end
      FN_START: begin
        has_res          = 1'b1;
        res.status_error = streaming;
        streaming_next   = 1'b1;
      end
      FN_STOP: begin
        has_res          = 1'b1;
        res.status_error = !streaming;
        streaming_next   = 1'b0;
      end
      FN_RESET: begin
        streaming_next     = 1'b0;
        line_width_next    = WIDTH_RESET;
        line_count_next    = HEIGHT_RESET;
        frame_counter_next = 16'd0;
        test_pattern_next  = 1'b0;
        clear_written      = 1'b1;
      end
      FN_READ: begin
        has_res             = 1'b1;
        res.reply_kind      = RK_SENSOR;
        res.read_address    = item.sensor_address;
        res.read_value      = (in_bank && written[idx]) ? rd_data : 16'd0;
        res.was_undefined   = !in_bank || (!written[idx] && !is_ctrl);
        res.was_unsupported = !in_bank || !is_ctrl;
      end
      FN_WRITE: begin
        has_res             = 1'b1;
        res.was_unsupported = !in_bank || !is_ctrl;
        mem_we              = in_bank;
        if (in_bank && is_ctrl) begin
          test_pattern_next = (item.sensor_value & PATTERN_MASK) == PATTERN_CODE;
        end
      end
      FN_PIXEL: begin
        if (streaming) begin
          has_res         = 1'b1;
          res.reply_kind  = RK_PIXEL;
          res.pixel_value = pix;
        end
      end
      FN_FRAME_END: begin
        if (streaming) frame_counter_next = frame_counter + 16'd1;
      end
      default: ;
    endcase
    res.frame_width  = line_width_next;
    res.frame_height = line_count_next;
    res.frame_count  = frame_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      streaming     <= 1'b0;
      line_width    <= WIDTH_RESET;
      line_count    <= HEIGHT_RESET;
      frame_counter <= 16'd0;
      test_pattern  <= 1'b0;
      written       <= '0;
    end else if (ctrl.commit) begin
      streaming     <= streaming_next;
      line_width    <= line_width_next;
      line_count    <= line_count_next;
      frame_counter <= frame_counter_next;
      test_pattern  <= test_pattern_next;
      if (clear_written) begin
        written <= '0;
      end else if (mem_we) begin
        written[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit && mem_we) sensor_mem[idx] <= item.sensor_value;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.commit && has_res) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit && has_res) rsp_item <= res;
  end

  assign status.has_result = has_res;
  assign status.out_busy   = rsp_valid && !rsp_ready;

endmodule

`default_nettype wire
